FILE: sv/sgmlms_pkg.sv
// ----------------------------------------------------------------------------
// sgmlms_pkg
// Types, codes and character constants shared by the markup splitter.
// ----------------------------------------------------------------------------
package sgmlms_pkg;

  localparam int CodeWidth = 32;  // width of the character code accumulator
  localparam int ValWidth  = 32;  // width of an event value
  localparam int MaxEvents = 3;   // events caused by one byte at most

  typedef enum logic [2:0] {
    EV_TEXT    = 3'd0,
    EV_TAG_BEG = 3'd1,
    EV_TAG_CHR = 3'd2,
    EV_TAG_END = 3'd3,
    EV_COM_BEG = 3'd4,
    EV_COM_CHR = 3'd5,
    EV_COM_END = 3'd6
  } evt_kind_e;

  typedef enum logic [12:0] {
    S_TEXT      = 13'b0000000000001,
    S_OPEN      = 13'b0000000000010,
    S_ZERO      = 13'b0000000000100,
    S_HEX       = 13'b0000000001000,
    S_DEC       = 13'b0000000010000,
    S_OCT       = 13'b0000000100000,
    S_TAG       = 13'b0000001000000,
    S_DASH      = 13'b0000010000000,
    S_COM       = 13'b0000100000000,
    S_COM_DASH  = 13'b0001000000000,
    S_QUOTE     = 13'b0010000000000,
    S_QUOTE_ESC = 13'b0100000000000,
    S_TAG_ESC   = 13'b1000000000000
  } parse_state_e;

  localparam logic [7:0] ChLt    = 8'h3C;  // '<'
  localparam logic [7:0] ChGt    = 8'h3E;  // '>'
  localparam logic [7:0] ChDash  = 8'h2D;  // '-'
  localparam logic [7:0] ChQuote = 8'h22;  // '"'
  localparam logic [7:0] ChBack  = 8'h5C;  // '\'
  localparam logic [7:0] ChZero  = 8'h30;  // '0'
  localparam logic [7:0] ChOne   = 8'h31;  // '1'
  localparam logic [7:0] ChSeven = 8'h37;  // '7'
  localparam logic [7:0] ChNine  = 8'h39;  // '9'
  localparam logic [7:0] ChLowA  = 8'h61;  // 'a'
  localparam logic [7:0] ChLowF  = 8'h66;  // 'f'
  localparam logic [7:0] ChUpA   = 8'h41;  // 'A'
  localparam logic [7:0] ChUpF   = 8'h46;  // 'F'
  localparam logic [7:0] ChLowX  = 8'h78;  // 'x'
  localparam logic [7:0] ChUpX   = 8'h58;  // 'X'

endpackage

FILE: sv/sgml_markup_splitter_top.sv
// ----------------------------------------------------------------------------
// sgml_markup_splitter_top
// Splits a markup byte stream into text, tag and comment events, decoding
// numeric character codes in angle brackets.
// ----------------------------------------------------------------------------
//  channel  | dir | tdata            | tuser          | tlast
//  s_axis   | in  | byte_in [7:0]    | -              | -
//  m_axis   | out | event_value[31:0]| event_kind[2:0]| last_of_run
//
// One byte is decoded in the cycle it is accepted; its 0 to 3 events are
// loaded into a three-entry result buffer and leave one per cycle while
// the output is ready, so a byte causing one event sustains one byte per
// cycle; more events stall input while the single output port drains them.
// Reset clears the parser to plain text and empties the result buffer.
// A stalled output holds the buffer; input is taken only when the buffer is
// empty or its last entry leaves in the same cycle.
// ----------------------------------------------------------------------------
module sgml_markup_splitter_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  input  logic [7:0]                        s_axis_tdata_i,   // byte_in[7:0]
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  output logic [sgmlms_pkg::ValWidth-1:0]   m_axis_tdata_o,   // event_value[31:0]
  output logic [2:0]                        m_axis_tuser_o,   // event_kind[2:0]
  output logic                              m_axis_tlast_o    // last_of_run
);
  import sgmlms_pkg::*;

  parse_state_e         state_q, state_d;
  logic                 ret_q, ret_d;
  logic [CodeWidth-1:0] acc_q, acc_d;

  evt_kind_e            kind_q [MaxEvents];
  logic [ValWidth-1:0]  val_q  [MaxEvents];
  logic [1:0]           cnt_q;

  evt_kind_e            ev_kind [MaxEvents];
  logic [ValWidth-1:0]  ev_val  [MaxEvents];
  logic [1:0]           ev_n;

  logic                 s_acc, m_pop;
  logic [7:0]           c;

  assign c = s_axis_tdata_i;
  assign s_axis_tready_o = (cnt_q == 2'd0) || ((cnt_q == 2'd1) && m_axis_tready_i);
  assign s_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign m_pop = m_axis_tvalid_o && m_axis_tready_i;

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = val_q[0];
  assign m_axis_tuser_o  = kind_q[0];
  assign m_axis_tlast_o  = (cnt_q == 2'd1);

  // Parser step for the byte at the input.
  always_comb begin
    logic [3:0]           dig;
    logic [CodeWidth-1:0] acc_code;
    logic [ValWidth-1:0]  cv;
    logic [ValWidth-1:0]  accv;
    dig      = 4'd0;
    acc_code = '0;
    cv       = ValWidth'(c);
    accv     = ValWidth'(acc_q);
    state_d  = state_q;
    ret_d    = ret_q;
    acc_d    = acc_q;
    ev_n     = 2'd0;
    for (int i = 0; i < MaxEvents; i++) begin
      ev_kind[i] = EV_TEXT;
      ev_val[i]  = '0;
    end

    if (c inside {[ChZero:ChNine]}) begin
      dig = 4'(c - ChZero);
    end else if (c inside {[ChLowA:ChLowF]}) begin
      dig = 4'(c - ChLowA + 8'd10);
    end else if (c inside {[ChUpA:ChUpF]}) begin
      dig = 4'(c - ChUpA + 8'd10);
    end
    case (state_q)
      S_HEX:   acc_code = (acc_q << 4) + CodeWidth'(dig);
      S_DEC:   acc_code = (acc_q << 3) + (acc_q << 1) + CodeWidth'(dig);
      default: acc_code = (acc_q << 3) + CodeWidth'(dig);
    endcase

    case (state_q)
      S_TEXT: begin
        if (c == ChLt) begin
          state_d = S_OPEN;
        end else begin
          ev_n = 2'd1; ev_kind[0] = EV_TEXT; ev_val[0] = cv;
        end
      end
      S_OPEN: begin
        acc_d = '0;
        if (c == ChZero) begin
          state_d = S_ZERO;
        end else if (c inside {[ChOne:ChNine]}) begin
          acc_d   = CodeWidth'(dig);
          state_d = S_DEC;
        end else if (c == ChDash) begin
          ret_d   = 1'b0;
          state_d = S_DASH;
        end else if (c == ChGt) begin
          state_d = S_TEXT;
        end else begin
          ev_n = 2'd2;
          ev_kind[0] = EV_TAG_BEG;
          ev_kind[1] = EV_TAG_CHR; ev_val[1] = cv;
          state_d = (c == ChQuote) ? S_QUOTE : (c == ChBack) ? S_TAG_ESC : S_TAG;
        end
      end
      S_ZERO: begin
        if (c == ChLowX || c == ChUpX) begin
          state_d = S_HEX;
        end else if (c inside {[ChZero:ChSeven]}) begin
          acc_d   = CodeWidth'(dig);
          state_d = S_OCT;
        end else if (c == ChGt) begin
          ev_n = 2'd1; ev_kind[0] = EV_TEXT;
          state_d = S_TEXT;
        end else begin
          ev_n = 2'd2;
          ev_kind[0] = EV_TAG_BEG;
          ev_kind[1] = EV_TAG_CHR; ev_val[1] = ValWidth'(ChZero);
          state_d = S_TAG;
        end
      end
      S_HEX, S_DEC, S_OCT: begin
        if ((state_q == S_HEX && (c inside {[ChZero:ChNine], [ChLowA:ChLowF],
                                            [ChUpA:ChUpF]})) ||
            (state_q == S_DEC && (c inside {[ChZero:ChNine]})) ||
            (state_q == S_OCT && (c inside {[ChZero:ChSeven]}))) begin
          acc_d = acc_code;
        end else if (c == ChGt) begin
          ev_n = 2'd1; ev_kind[0] = EV_TEXT; ev_val[0] = accv;
          state_d = S_TEXT;
        end else begin
          // Malformed code: the digits so far become one tag character.
          ev_n = 2'd2;
          ev_kind[0] = EV_TAG_BEG;
          ev_kind[1] = EV_TAG_CHR; ev_val[1] = accv;
          state_d = S_TAG;
        end
      end
      S_TAG: begin
        if (c == ChGt) begin
          ev_n = 2'd1; ev_kind[0] = EV_TAG_END;
          state_d = S_TEXT;
        end else if (c == ChDash) begin
          ret_d   = 1'b1;
          state_d = S_DASH;
        end else begin
          ev_n = 2'd1; ev_kind[0] = EV_TAG_CHR; ev_val[0] = cv;
          if (c == ChQuote) begin
            state_d = S_QUOTE;
          end else if (c == ChBack) begin
            state_d = S_TAG_ESC;
          end
        end
      end
      S_DASH: begin
        if (c == ChDash) begin
          ev_n = 2'd1; ev_kind[0] = EV_COM_BEG;
          state_d = S_COM;
        end else if (c == ChGt) begin
          ev_n = 2'd3;
          ev_kind[0] = EV_TAG_BEG;
          ev_kind[1] = EV_TAG_CHR; ev_val[1] = ValWidth'(ChDash);
          ev_kind[2] = EV_TAG_END;
          state_d = S_TEXT;
        end else if (!ret_q) begin
          ev_n = 2'd3;
          ev_kind[0] = EV_TAG_BEG;
          ev_kind[1] = EV_TAG_CHR; ev_val[1] = ValWidth'(ChDash);
          ev_kind[2] = EV_TAG_CHR; ev_val[2] = cv;
          state_d = S_TAG;
        end else begin
          ev_n = 2'd2;
          ev_kind[0] = EV_TAG_CHR; ev_val[0] = ValWidth'(ChDash);
          ev_kind[1] = EV_TAG_CHR; ev_val[1] = cv;
          state_d = S_TAG;
        end
      end
      S_COM: begin
        if (c == ChDash) begin
          state_d = S_COM_DASH;
        end else begin
          ev_n = 2'd1; ev_kind[0] = EV_COM_CHR; ev_val[0] = cv;
        end
      end
      S_COM_DASH: begin
        if (c == ChDash) begin
          ev_n = 2'd1; ev_kind[0] = EV_COM_END;
          state_d = ret_q ? S_TAG : S_OPEN;
        end else begin
          ev_n = 2'd2;
          ev_kind[0] = EV_COM_CHR; ev_val[0] = ValWidth'(ChDash);
          ev_kind[1] = EV_COM_CHR; ev_val[1] = cv;
          state_d = S_COM;
        end
      end
      S_QUOTE: begin
        ev_n = 2'd1; ev_kind[0] = EV_TAG_CHR; ev_val[0] = cv;
        if (c == ChQuote) begin
          state_d = S_TAG;
        end else if (c == ChBack) begin
          state_d = S_QUOTE_ESC;
        end
      end
      S_QUOTE_ESC: begin
        ev_n = 2'd1; ev_kind[0] = EV_TAG_CHR; ev_val[0] = cv;
        state_d = S_QUOTE;
      end
      S_TAG_ESC: begin
        ev_n = 2'd1; ev_kind[0] = EV_TAG_CHR; ev_val[0] = cv;
        state_d = S_TAG;
      end
      default: begin
        state_d = S_TEXT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_TEXT;
      ret_q   <= 1'b0;
      acc_q   <= '0;
    end else if (s_acc) begin
      state_q <= state_d;
      ret_q   <= ret_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else if (s_acc) begin
      cnt_q <= ev_n;
    end else if (m_pop) begin
      cnt_q <= cnt_q - 2'd1;
    end
  end

  // Head of the buffer is always entry 0; a pop shifts the rest down.
  always_ff @(posedge clk_i) begin
    if (s_acc) begin
      for (int i = 0; i < MaxEvents; i++) begin
        kind_q[i] <= ev_kind[i];
        val_q[i]  <= ev_val[i];
      end
    end else if (m_pop) begin
      for (int i = 0; i < MaxEvents - 1; i++) begin
        kind_q[i] <= kind_q[i+1];
        val_q[i]  <= val_q[i+1];
      end
    end
  end

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q != 2'd3 || MaxEvents == 3)
    else $error("result count out of range");

  a_accept_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |-> (cnt_q == 2'd0 || (cnt_q == 2'd1 && m_axis_tready_i)))
    else $error("byte accepted over pending results");

  a_pop_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_pop && !s_acc) |=> cnt_q == $past(cnt_q) - 2'd1)
    else $error("result count not decremented on pop");

  a_text_event: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_acc && state_q == S_TEXT && c != ChLt) |=>
      (cnt_q == 2'd1 && m_axis_tuser_o == EV_TEXT && m_axis_tdata_o == ValWidth'($past(c))))
    else $error("plain byte did not give one text event");

endmodule
